/* rtl/keyword_token_matcher_top_defines.svh */
// ----------------------------------------------------------------------------
// keyword_token_matcher_top_defines.svh
// Assertion macros used by the checker file of the keyword matcher.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_MATCHER_TOP_DEFINES_SVH
`define KEYWORD_TOKEN_MATCHER_TOP_DEFINES_SVH

// checked outside reset
`define KTM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("keyword matcher check failed");

// checked at every edge, reset included
`define KTM_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("keyword matcher check failed");

`endif

/* rtl/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Keyword table, widths and shared types of the keyword token matcher.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int KW_COUNT   = 20;
	localparam int KW_MAX_LEN = 10;
	localparam int TOKEN_BASE = 128;
	localparam int POS_W      = 4;
	localparam int TOKEN_W    = 8;
	localparam int CH_W       = 8;

	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

	// right aligned: first char sits in the highest used byte
	localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"REM", "LET", "IF", "GOTO", "LIST", "VARS", "PRINT", "RUN", "CLEAR",
		"DOT", "GOSUB", "RET", "PRINTS", "DUMP", "COLOR", "DEBUG", "BREAKPOINT",
		"RESUME", "CURSOR", "DELAY"
	};

	localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd3, 4'd2, 4'd4, 4'd4, 4'd4, 4'd5, 4'd3, 4'd5, 4'd3,
		4'd5, 4'd3, 4'd6, 4'd4, 4'd5, 4'd5, 4'd10, 4'd6, 4'd6, 4'd5
	};

	typedef struct packed {
		logic [KW_COUNT-1:0] mask;
		logic [POS_W-1:0]    pos;
		logic                done;
	} kwm_state_t;

	typedef struct packed {
		logic               valid;
		logic [TOKEN_W-1:0] token;
		logic [POS_W-1:0]   consumed;
	} kwm_result_t;

endpackage

/* rtl/kwm_match.sv */
// ----------------------------------------------------------------------------
// kwm_match
// Per-character step: parallel compare against all keywords, next state and
// the token for a terminated word.
// ----------------------------------------------------------------------------
module kwm_match import kwm_pkg::*; (
	input  kwm_state_t      state,
	input  logic [CH_W-1:0] ch,
	input  logic            line_start,
	output kwm_state_t      next_state,
	output kwm_result_t     result
);

	kwm_state_t          cur;
	logic [KW_COUNT-1:0] hit;
	logic [KW_COUNT-1:0] len_eq;
	logic [POS_W-1:0]    byte_sel;
	logic                term;

	always_comb begin
		cur = state;
		if (line_start) begin
			cur.mask = {KW_COUNT{1'b1}};
			cur.pos  = '0;
			cur.done = 1'b0;
		end
	end

	assign term = (ch == CH_SPACE) || (ch == CH_NUL);

	always_comb begin
		hit      = '0;
		len_eq   = '0;
		byte_sel = '0;
		for (int i = 0; i < KW_COUNT; i++) begin
			byte_sel = KW_LEN[i] - 4'd1 - cur.pos;
			hit[i] = (cur.pos < KW_LEN[i]) &&
				(KW_TEXT[i][{byte_sel, 3'b000} +: 8] == ch);
			len_eq[i] = cur.mask[i] && (KW_LEN[i] == cur.pos);
		end
	end

	always_comb begin
		result   = '0;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (len_eq[i]) begin
				result.token    = TOKEN_W'(TOKEN_BASE + i);
				result.consumed = KW_LEN[i];
			end
		end
		next_state = cur;
		if (cur.done) begin
			result = '0;
		end else if (term) begin
			result.valid    = 1'b1;
			next_state.done = 1'b1;
		end else begin
			result = '0;
			if (cur.pos >= POS_W'(KW_MAX_LEN)) begin
				next_state.mask = '0;
			end else begin
				next_state.mask = cur.mask & hit;
				next_state.pos  = cur.pos + 4'd1;
			end
		end
	end

endmodule

/* rtl/keyword_token_matcher_top.sv */
// ----------------------------------------------------------------------------
// keyword_token_matcher_top
// Matches the leading word of a command line against a fixed keyword table.
// ----------------------------------------------------------------------------
// One character beat is taken every cycle. A character passes an input
// register, is compared against all twenty keywords at once while the match
// state updates, and a terminating space or NUL loads the result register, so
// a token appears once its terminator has passed both registers. The single
// bank of parallel keyword comparators sets this one-character-per-cycle rate.
// Input is stalled only while the result register holds an untaken token.
module keyword_token_matcher_top import kwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CH_W-1:0]    ch,
	input  logic               line_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TOKEN_W-1:0] token,
	output logic [POS_W-1:0]   consumed
);

	logic               valid_s1;
	logic [CH_W-1:0]    ch_s1;
	logic               line_start_s1;
	kwm_state_t         state_q;
	kwm_state_t         next_state;
	kwm_result_t        res;
	logic               out_valid_q;
	logic [TOKEN_W-1:0] token_q;
	logic [POS_W-1:0]   consumed_q;
	logic               advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	kwm_match u_match (
		.state      (state_q),
		.ch         (ch_s1),
		.line_start (line_start_s1),
		.next_state (next_state),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			state_q.mask  <= {KW_COUNT{1'b1}};
			state_q.pos   <= '0;
			state_q.done  <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && advance) begin
				state_q <= next_state;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1         <= ch;
			line_start_s1 <= line_start;
		end
		if (advance && valid_s1 && res.valid) begin
			token_q    <= res.token;
			consumed_q <= res.consumed;
		end
	end

	assign out_valid = out_valid_q;
	assign token     = token_q;
	assign consumed  = consumed_q;

endmodule

/* rtl/kwm_checker.sv */
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the keyword token matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyword_token_matcher_top_defines.svh"

module kwm_checker import kwm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [CH_W-1:0]    ch,
	input logic               line_start,
	input logic               out_valid,
	input logic               out_ready,
	input logic [TOKEN_W-1:0] token,
	input logic [POS_W-1:0]   consumed
);

	`KTM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(token) && $stable(consumed))
	`KTM_ASSERT(a_token_code, out_valid |-> (token == '0 && consumed == '0) || (token >= TOKEN_W'(TOKEN_BASE) && token < TOKEN_W'(TOKEN_BASE + KW_COUNT) && consumed != '0 && consumed <= POS_W'(KW_MAX_LEN)))
	`KTM_ASSERT(a_no_backpressure, out_ready |-> in_ready)
	`KTM_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid)

endmodule

bind keyword_token_matcher_top kwm_checker u_kwm_checker (.*);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyword_token_matcher_top: directed lines (empty
// word, discarded word, exact and longest keywords, odd bytes) followed by
// random command lines, with random idling on both channels and a long
// output hold-off. Every beat taken is run through a predictor; tokens coming
// out are compared in order against what it expects.
// ----------------------------------------------------------------------------
module tb;
	import kwm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_WORDS    = 20;
	localparam int WORD_MAX   = 10;
	localparam int TOK_OFFSET = 128;
	localparam int IDLE_PCT   = 38;
	localparam int WORD_BEATS = 1200;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		logic [TOKEN_W-1:0] tok;
		logic [POS_W-1:0]   cons;
	} word_result_t;

	typedef struct packed {
		logic [CH_W-1:0]    c;
		logic               ls;
		logic               pin;
		logic [TOKEN_W-1:0] tok;
		logic [POS_W-1:0]   cons;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [CH_W-1:0]    ch;
	logic               line_start;
	logic               out_valid;
	logic               out_ready;
	logic [TOKEN_W-1:0] token;
	logic [POS_W-1:0]   consumed;

	string kw_words [N_WORDS] = '{
		"REM", "LET", "IF", "GOTO", "LIST", "VARS", "PRINT", "RUN", "CLEAR",
		"DOT", "GOSUB", "RET", "PRINTS", "DUMP", "COLOR", "DEBUG", "BREAKPOINT",
		"RESUME", "CURSOR", "DELAY"
	};

	stim_row_t directed_rows [27] = '{
		'{"X", 1'b0, 1'b0, 8'd0, 4'd0},
		'{CH_SPACE, 1'b1, 1'b1, 8'd0, 4'd0},
		'{"G", 1'b1, 1'b0, 8'd0, 4'd0},
		'{"O", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"I", 1'b1, 1'b0, 8'd0, 4'd0},
		'{"F", 1'b0, 1'b0, 8'd0, 4'd0},
		'{CH_SPACE, 1'b0, 1'b1, 8'd130, 4'd2},
		'{"P", 1'b1, 1'b0, 8'd0, 4'd0},
		'{"R", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"I", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"N", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"T", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"S", 1'b0, 1'b0, 8'd0, 4'd0},
		'{CH_NUL, 1'b0, 1'b1, 8'd140, 4'd6},
		'{"B", 1'b1, 1'b0, 8'd0, 4'd0},
		'{"R", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"E", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"A", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"K", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"P", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"O", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"I", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"N", 1'b0, 1'b0, 8'd0, 4'd0},
		'{"T", 1'b0, 1'b0, 8'd0, 4'd0},
		'{CH_SPACE, 1'b0, 1'b1, 8'd144, 4'd10},
		'{8'hFF, 1'b1, 1'b0, 8'd0, 4'd0},
		'{CH_SPACE, 1'b0, 1'b1, 8'd0, 4'd0}
	};

	logic [N_WORDS-1:0] cand_mask;
	logic [POS_W-1:0]   word_pos;
	logic               word_closed;

	word_result_t pending_tokens [$];
	int           mismatches;
	int           beats_sent;
	bit           in_calm;
	bit           out_calm;
	bit           hold_done;
	int           hold_left;

	keyword_token_matcher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.line_start(line_start),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.token     (token),
		.consumed  (consumed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// returns 1 when the beat closes a word
	function automatic bit match_char(input logic [CH_W-1:0] c, input logic ls,
			output word_result_t r);
		bit found;
		found = 1'b0;
		r = '0;
		if (ls) begin
			cand_mask = '1;
			word_pos = '0;
			word_closed = 1'b0;
		end
		if (word_closed)
			return 1'b0;
		if (c == CH_SPACE || c == CH_NUL) begin
			for (int i = 0; i < N_WORDS; i++) begin
				if (!found && cand_mask[i] && kw_words[i].len() == int'(word_pos)) begin
					found = 1'b1;
					r.tok = TOKEN_W'(TOK_OFFSET + i);
					r.cons = word_pos;
				end
			end
			word_closed = 1'b1;
			return 1'b1;
		end
		if (int'(word_pos) >= WORD_MAX) begin
			cand_mask = '0;
			return 1'b0;
		end
		for (int i = 0; i < N_WORDS; i++) begin
			if (int'(word_pos) >= kw_words[i].len() || kw_words[i][word_pos] != c)
				cand_mask[i] = 1'b0;
		end
		word_pos = word_pos + 1'b1;
		return 1'b0;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_char(input logic [CH_W-1:0] c, input logic ls, input logic pin,
			input logic [TOKEN_W-1:0] ptok, input logic [POS_W-1:0] pcons);
		int gap;
		word_result_t r;
		gap = 0;
		if (!in_calm)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		line_start <= ls;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (match_char(c, ls, r) || pin) begin
			if (pin) begin
				r.tok = ptok;
				r.cons = pcons;
			end
			pending_tokens.push_back(r);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_tokens.size() != 0);
	endtask

	function automatic logic [CH_W-1:0] rand_word_byte();
		logic [CH_W-1:0] c;
		do c = CH_W'($urandom_range(255)); while (c == CH_SPACE || c == CH_NUL);
		return c;
	endfunction

	function automatic logic [CH_W-1:0] rand_letter();
		return CH_W'($urandom_range(8'h5A, 8'h41));
	endfunction

	// one random command line; returns the beats that reach the matcher
	task automatic send_line(output int used);
		logic [CH_W-1:0] w [$];
		int kind, k, n;
		bit unterminated;
		kind = $urandom_range(99);
		k = $urandom_range(N_WORDS - 1);
		unterminated = ($urandom_range(99) < 8);
		if (kind < 70)
			for (int j = 0; j < kw_words[k].len(); j++)
				w.push_back(kw_words[k][j]);
		if (kind >= 45 && kind < 55) begin
			repeat ($urandom_range(3, 1)) w.push_back(rand_letter());
		end else if (kind >= 55 && kind < 63) begin
			repeat ($urandom_range(w.size(), 1)) void'(w.pop_back());
		end else if (kind >= 63 && kind < 70) begin
			w[$urandom_range(w.size() - 1)] = rand_word_byte();
		end else if (kind >= 70 && kind < 80) begin
			repeat ($urandom_range(8)) w.push_back(rand_letter());
		end else if (kind >= 80 && kind < 88) begin
			if ($urandom_range(1))
				for (int j = 0; j < kw_words[16].len(); j++)
					w.push_back(kw_words[16][j]);
			n = $urandom_range(14, 10);
			while (w.size() < n)
				w.push_back(rand_letter());
		end else if (kind >= 88) begin
			repeat ($urandom_range(12)) w.push_back(rand_word_byte());
		end
		foreach (w[j])
			send_char(w[j], j == 0, 1'b0, '0, '0);
		used = w.size();
		if (unterminated && w.size() > 0)
			return;
		send_char($urandom_range(1) ? CH_SPACE : CH_NUL, w.size() == 0, 1'b0, '0, '0);
		used++;
		repeat ($urandom_range(2)) begin
			send_char(CH_W'($urandom_range(255)), 1'b0, 1'b0, '0, '0);
			used++;
		end
	endtask

	always @(posedge clk) begin
		word_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected beat token=%0d consumed=%0d",
					token, consumed));
			end else begin
				want = pending_tokens.pop_front();
				if (token !== want.tok)
					report_mismatch($sformatf("token %0d, expected %0d", token, want.tok));
				if (consumed !== want.cons)
					report_mismatch($sformatf("consumed %0d, expected %0d",
						consumed, want.cons));
			end
		end
	end

	// receiver: random stalls, one long hold-off, a calm stretch
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && beats_sent >= 400) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (out_calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int word_count, used;
		bit paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		line_start = 1'b0;
		cand_mask = '1;
		word_pos = '0;
		word_closed = 1'b1;
		mismatches = 0;
		beats_sent = 0;
		hold_left = 0;
		word_count = 0;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_char(directed_rows[i].c, directed_rows[i].ls, directed_rows[i].pin,
				directed_rows[i].tok, directed_rows[i].cons);

		while (word_count < WORD_BEATS) begin
			in_calm = (word_count >= 200 && word_count < 350);
			out_calm = in_calm;
			if (!paused && word_count >= 800) begin
				paused = 1'b1;
				wait_drained();
			end
			send_line(used);
			word_count += used;
		end
		in_calm = 1'b0;
		out_calm = 1'b0;

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_tokens.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
